// ===== hw/rtl/stree_pkg.sv =====
`default_nettype none

package stree_pkg;

    // fixed field widths of the item ports
    localparam int CMD_W  = 1;
    localparam int POS_W  = 11;
    localparam int VAL_W  = 16;
    localparam int OUT_W  = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_QUERY  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 1'b1;

    // top level sequencer
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD,
        ST_QRY
    } stree_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/segment_tree_range_max.sv =====
`default_nettype none

// channel   direction   handshake            payload
// in        in          in_valid, in_ready   cmd, range_low, range_high,
//                                            update_index, update_value
// out       out         out_valid, out_ready range_maximum
//
// an update writes one node per tree level from the leaf up to the root,
// the sibling read overlapped with it
// a query walks one level per cycle through the two read ports, then merges
// the last pair; the walk ends below the root when the range closes there
// an update with a bad index is taken and dropped; an invalid query returns zero
// after reset the node memory is swept to zero, with in_ready low
// a query result waits in the output register; the next item is still taken,
// a later query only stalls at its end while that register is full
module segment_tree_range_max
    import stree_pkg::*;
#(
    parameter int LEAVES      = 1024,
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [CMD_W-1:0] cmd,
    input  wire logic [POS_W-1:0] range_low,
    input  wire logic [POS_W-1:0] range_high,
    input  wire logic [POS_W-1:0] update_index,
    input  wire logic [VAL_W-1:0] update_value,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [OUT_W-1:0] range_maximum
);

    // node address width: nodes 1 .. 2*LEAVES-1, heap order
    localparam int AW    = $clog2(LEAVES) + 1;
    // walk bounds need one more bit, the left bound may step past the last node
    localparam int NW    = AW + 1;
    localparam int DEPTH = 2 * LEAVES;

    stree_state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] range_maximum_reg, range_maximum_next;

    logic accept;
    logic idx_ok, qry_ok;
    logic upd_start, qry_start;
    logic [AW-1:0] leaf_node;
    logic [NW-1:0] left_init, right_init;

    // memory ports
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    logic [VALUE_WIDTH-1:0] mem_wr_data;
    logic [AW-1:0]          mem_rd_addr_a, mem_rd_addr_b;
    logic [VALUE_WIDTH-1:0] mem_rd_data_a, mem_rd_data_b;

    // walker connections
    logic                   upd_busy, upd_done, upd_wr_en;
    logic [AW-1:0]          upd_wr_addr, upd_rd_addr;
    logic [VALUE_WIDTH-1:0] upd_wr_data;
    logic                   qry_busy, qry_done, slot_free;
    logic [VALUE_WIDTH-1:0] qry_best;
    logic [AW-1:0]          qry_rd_addr_a, qry_rd_addr_b;

    assign in_ready      = (state_reg == ST_IDLE);
    assign accept        = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign range_maximum = range_maximum_reg;
    assign slot_free     = !out_valid_reg || out_ready;

    // bounds checks are done wide so that any leaf count compares correctly
    assign idx_ok = (update_index != '0) && (32'(update_index) <= 32'(LEAVES));
    assign qry_ok = (range_low != '0) && (32'(range_high) <= 32'(LEAVES))
                    && (range_low <= range_high);

    // leaf position p lives at node LEAVES+p-1
    assign leaf_node = AW'(LEAVES) + AW'(update_index) - AW'(1);

    // an invalid query starts with an empty window and returns zero
    assign left_init  = qry_ok ? (NW'(LEAVES) + NW'(range_low) - NW'(1)) : NW'(1);
    assign right_init = qry_ok ? (NW'(LEAVES) + NW'(range_high) - NW'(1)) : NW'(0);

    assign upd_start = accept && (cmd == CMD_UPDATE) && idx_ok;
    assign qry_start = accept && (cmd == CMD_QUERY);

    always_comb
    begin
        state_next         = state_reg;
        clr_next           = clr_reg;
        out_valid_next     = out_valid_reg;
        range_maximum_next = range_maximum_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (qry_done)
        begin
            out_valid_next     = 1'b1;
            range_maximum_next = OUT_W'(qry_best);
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (upd_start)
                begin
                    state_next = ST_UPD;
                end
                else if (qry_start)
                begin
                    state_next = ST_QRY;
                end
            end
            ST_UPD:
            begin
                if (upd_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QRY:
            begin
                if (qry_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_maximum_reg <= range_maximum_next;
    end

    // the sweep owns the write port after reset, the update walker after that
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_reg;
            mem_wr_data = '0;
        end
        else
        begin
            mem_wr_en   = upd_wr_en;
            mem_wr_addr = upd_wr_addr;
            mem_wr_data = upd_wr_data;
        end
        mem_rd_addr_a = qry_busy ? qry_rd_addr_a : upd_rd_addr;
        mem_rd_addr_b = qry_rd_addr_b;
    end

    stree_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .rd_addr_a (mem_rd_addr_a),
        .rd_data_a (mem_rd_data_a),
        .rd_addr_b (mem_rd_addr_b),
        .rd_data_b (mem_rd_data_b)
    );

    stree_upd #(
        .LEAVES      (LEAVES),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_upd (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (upd_start),
        .leaf_node (leaf_node),
        .value     (VALUE_WIDTH'(update_value)),
        .rd_data   (mem_rd_data_a),
        .busy      (upd_busy),
        .done      (upd_done),
        .wr_en     (upd_wr_en),
        .wr_addr   (upd_wr_addr),
        .wr_data   (upd_wr_data),
        .rd_addr   (upd_rd_addr)
    );

    stree_qry #(
        .LEAVES      (LEAVES),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW),
        .NW          (NW)
    ) u_qry (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (qry_start),
        .left_init  (left_init),
        .right_init (right_init),
        .rd_data_a  (mem_rd_data_a),
        .rd_data_b  (mem_rd_data_b),
        .slot_free  (slot_free),
        .busy       (qry_busy),
        .done       (qry_done),
        .best       (qry_best),
        .rd_addr_a  (qry_rd_addr_a),
        .rd_addr_b  (qry_rd_addr_b)
    );

    // the two walkers never share the memory
    a_walkers_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(upd_busy && qry_busy))
        else $error("update and query walkers active together");

    // a new item is only taken once both walkers have finished
    a_ready_only_when_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!upd_busy && !qry_busy))
        else $error("item taken while a walk is in progress");

    // a result never overwrites one that is still waiting
    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        qry_done |-> (!out_valid_reg || out_ready))
        else $error("query result would overwrite a pending result");

    // an accepted query always starts the query walker
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_QUERY)) |=> qry_busy)
        else $error("query accepted but walker idle");

    // nothing is written to the tree during a query
    a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
        qry_busy |-> !mem_wr_en)
        else $error("memory written during a query walk");

endmodule

`default_nettype wire

// ===== hw/rtl/stree_ram.sv =====
`default_nettype none

// one write port, two registered read ports
module stree_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stree_upd.sv =====
`default_nettype none

// leaf-to-root walk: each cycle writes one node and reads the sibling
// whose value the parent needs in the next cycle
module stree_upd #(
    parameter int LEAVES      = 1024,
    parameter int VALUE_WIDTH = 16,
    parameter int AW          = $clog2(LEAVES) + 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [AW-1:0]          leaf_node,
    input  wire logic [VALUE_WIDTH-1:0] value,
    input  wire logic [VALUE_WIDTH-1:0] rd_data,
    output logic                        busy,
    output logic                        done,
    output logic                        wr_en,
    output logic      [AW-1:0]          wr_addr,
    output logic      [VALUE_WIDTH-1:0] wr_data,
    output logic      [AW-1:0]          rd_addr
);

    logic                   busy_reg, busy_next;
    logic                   first_reg, first_next;
    logic [AW-1:0]          node_reg, node_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;

    always_comb
    begin
        // parent value is the larger of the running value and the sibling
        if (first_reg || (val_reg >= rd_data))
        begin
            wr_data = val_reg;
        end
        else
        begin
            wr_data = rd_data;
        end
        wr_en   = busy_reg;
        wr_addr = node_reg;
        rd_addr = node_reg ^ AW'(1);
        busy    = busy_reg;
        done    = busy_reg && (node_reg == AW'(1));

        busy_next  = busy_reg;
        first_next = first_reg;
        node_next  = node_reg;
        val_next   = val_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            first_next = 1'b1;
            node_next  = leaf_node;
            val_next   = value;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_next = 1'b0;
            end
            first_next = 1'b0;
            node_next  = node_reg >> 1;
            val_next   = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
        node_reg  <= node_next;
        val_reg   <= val_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stree_qry.sv =====
`default_nettype none

// bottom-up range walk: reads both bound nodes each level, merges them in the
// following cycle while the next level's reads are already out
module stree_qry #(
    parameter int LEAVES      = 1024,
    parameter int VALUE_WIDTH = 16,
    parameter int AW          = $clog2(LEAVES) + 1,
    parameter int NW          = AW + 1
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [NW-1:0]          left_init,
    input  wire logic [NW-1:0]          right_init,
    input  wire logic [VALUE_WIDTH-1:0] rd_data_a,
    input  wire logic [VALUE_WIDTH-1:0] rd_data_b,
    input  wire logic                   slot_free,
    output logic                        busy,
    output logic                        done,
    output logic      [VALUE_WIDTH-1:0] best,
    output logic      [AW-1:0]          rd_addr_a,
    output logic      [AW-1:0]          rd_addr_b
);

    logic                   busy_reg, busy_next;
    logic                   pend_reg, pend_next;
    logic                   take_l_reg, take_l_next;
    logic                   take_r_reg, take_r_next;
    logic [NW-1:0]          left_reg, left_next;
    logic [NW-1:0]          right_reg, right_next;
    logic [VALUE_WIDTH-1:0] best_reg, best_next;
    logic [VALUE_WIDTH-1:0] cand_a, cand_b, merge_a;
    logic                   walk;

    always_comb
    begin
        cand_a  = (pend_reg && take_l_reg) ? rd_data_a : '0;
        cand_b  = (pend_reg && take_r_reg) ? rd_data_b : '0;
        merge_a = (cand_a > best_reg) ? cand_a : best_reg;
        best    = (cand_b > merge_a) ? cand_b : merge_a;

        walk      = busy_reg && (left_reg <= right_reg);
        done      = busy_reg && !walk && slot_free;
        busy      = busy_reg;
        rd_addr_a = AW'(left_reg);
        rd_addr_b = AW'(right_reg);

        busy_next   = busy_reg;
        pend_next   = pend_reg;
        take_l_next = take_l_reg;
        take_r_next = take_r_reg;
        left_next   = left_reg;
        right_next  = right_reg;
        best_next   = best_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            pend_next  = 1'b0;
            left_next  = left_init;
            right_next = right_init;
            best_next  = '0;
        end
        else if (busy_reg)
        begin
            best_next = best;
            if (walk)
            begin
                // left odd: take it and step right; right even: take it and step left
                pend_next   = 1'b1;
                take_l_next = left_reg[0];
                take_r_next = !right_reg[0];
                left_next   = (left_reg + NW'(left_reg[0])) >> 1;
                right_next  = (right_reg - NW'(!right_reg[0])) >> 1;
            end
            else
            begin
                pend_next = 1'b0;
                if (slot_free)
                begin
                    busy_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        take_l_reg <= take_l_next;
        take_r_reg <= take_r_next;
        left_reg   <= left_next;
        right_reg  <= right_next;
        best_reg   <= best_next;
    end

endmodule

`default_nettype wire
